/* rtl/ssid_pkg.sv */
// ----------------------------------------------------------------------------
// ssid_pkg
// shared widths and defaults for the square spiral index distance unit
// ----------------------------------------------------------------------------
`default_nettype none

package ssid_pkg;

    // default width of one spiral index
    localparam int INDEX_WIDTH_DEF = 32;

    // widths of the result fields
    localparam int COORD_W = 17;
    localparam int DIST_W  = 18;

endpackage

`default_nettype wire

/* rtl/ssid_lane.sv */
// ----------------------------------------------------------------------------
// ssid_lane
// maps one spiral index to grid coordinates: pipelined digit-by-digit
// square root, then ring offset and side selection
// ----------------------------------------------------------------------------
`default_nettype none

module ssid_lane #(
    parameter int INDEX_WIDTH = ssid_pkg::INDEX_WIDTH_DEF
) (
    input  wire logic                                    clk,
    input  wire logic                                    advance,
    input  wire logic [INDEX_WIDTH-1:0]                  index,
    output logic signed [(INDEX_WIDTH+1)/2+3:0]          x,
    output logic signed [(INDEX_WIDTH+1)/2+3:0]          y
);

    localparam int RootW  = (INDEX_WIDTH + 1) / 2;
    localparam int RadW   = 2 * RootW;
    localparam int RemW   = RootW + 2;
    localparam int OffW   = RootW + 3;
    localparam int CoordW = RootW + 4;

    logic [INDEX_WIDTH-1:0] index_m1;
    logic [RadW-1:0]        val_reg  [RootW];
    logic [RootW-1:0]       root_reg [RootW];
    logic [RemW-1:0]        rem_reg  [RootW];

    // radicand is index-1, index zero behaves like index one
    assign index_m1 = (index == '0) ? '0 : index - INDEX_WIDTH'(1);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            val_reg[0] <= RadW'(index_m1);
        end
    end

    // one root bit per stage
    for (genvar j = 0; j < RootW; j++)
    begin : g_step
        logic [RemW-1:0]  rem_in;
        logic [RootW-1:0] root_in;
        logic [RemW-1:0]  rem_sh;
        logic [RemW-1:0]  trial;
        logic             ge;

        if (j == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
        end

        assign rem_sh = {rem_in[RootW-1:0], val_reg[j][RadW-1 -: 2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[j]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[j] <= {root_in[RootW-2:0], ge};
            end
        end

        if (j < RootW - 1)
        begin : g_val
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    val_reg[j+1] <= val_reg[j] << 2;
                end
            end
        end
    end

    // ring number and offset along the ring
    logic [RootW-1:0] root;
    logic [RemW-1:0]  rem;
    logic [RootW:0]   root_p1;
    logic             kz_reg;
    logic [OffW-1:0]  k_reg, h_reg, k2_reg, k3_reg, k4_reg, k5_reg, k6_reg, k7_reg;
    logic [OffW-1:0]  k_next;

    assign root    = root_reg[RootW-1];
    assign rem     = rem_reg[RootW-1];
    assign root_p1 = {1'b0, root} + (RootW+1)'(1);
    assign k_next  = OffW'(root_p1[RootW:1]);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            kz_reg <= (root == '0);
            k_reg  <= k_next;
            // odd root: ring base is root^2, even root: base is (root-1)^2
            h_reg  <= root[0] ? (OffW'(rem) + OffW'(1))
                              : (OffW'(rem) + OffW'({root, 1'b0}));
            k2_reg <= k_next << 1;
            k3_reg <= (k_next << 1) + k_next;
            k4_reg <= k_next << 2;
            k5_reg <= (k_next << 2) + k_next;
            k6_reg <= (k_next << 2) + (k_next << 1);
            k7_reg <= (k_next << 3) - k_next;
        end
    end

    // side of the ring
    logic signed [CoordW-1:0] ks, hs, k3s, k5s, k7s;
    logic signed [CoordW-1:0] x_next, y_next;
    logic signed [CoordW-1:0] x_reg, y_reg;

    assign ks  = $signed(CoordW'(k_reg));
    assign hs  = $signed(CoordW'(h_reg));
    assign k3s = $signed(CoordW'(k3_reg));
    assign k5s = $signed(CoordW'(k5_reg));
    assign k7s = $signed(CoordW'(k7_reg));

    always_comb
    begin
        priority if (kz_reg)
        begin
            x_next = '0;
            y_next = '0;
        end
        else if (h_reg <= k2_reg)
        begin
            x_next = hs - ks;
            y_next = -ks;
        end
        else if (h_reg <= k4_reg)
        begin
            x_next = ks;
            y_next = hs - k3s;
        end
        else if (h_reg <= k6_reg)
        begin
            x_next = k5s - hs;
            y_next = ks;
        end
        else
        begin
            x_next = -ks;
            y_next = k7s - hs;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    assign x = x_reg;
    assign y = y_reg;

endmodule

`default_nettype wire

/* rtl/ssid_merge.sv */
// ----------------------------------------------------------------------------
// ssid_merge
// combines the two lane points: absolute differences, distance sum and
// the output register
// ----------------------------------------------------------------------------
`default_nettype none

module ssid_merge #(
    parameter int INDEX_WIDTH = ssid_pkg::INDEX_WIDTH_DEF
) (
    input  wire logic                                    clk,
    input  wire logic                                    advance,
    input  wire logic signed [(INDEX_WIDTH+1)/2+3:0]     ax,
    input  wire logic signed [(INDEX_WIDTH+1)/2+3:0]     ay,
    input  wire logic signed [(INDEX_WIDTH+1)/2+3:0]     bx,
    input  wire logic signed [(INDEX_WIDTH+1)/2+3:0]     by,
    output logic signed [ssid_pkg::COORD_W-1:0]          first_x,
    output logic signed [ssid_pkg::COORD_W-1:0]          first_y,
    output logic signed [ssid_pkg::COORD_W-1:0]          second_x,
    output logic signed [ssid_pkg::COORD_W-1:0]          second_y,
    output logic [ssid_pkg::DIST_W-1:0]                  manhattan_distance
);

    localparam int CoordW = (INDEX_WIDTH + 1) / 2 + 4;
    localparam int OutW   = ssid_pkg::COORD_W;
    localparam int DistW  = ssid_pkg::DIST_W;

    logic signed [CoordW:0]   dx, dy;
    logic [CoordW:0]          adx_reg, ady_reg;
    logic signed [CoordW-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [CoordW+1:0]        sum;

    // sign-extend by one bit so the difference cannot overflow
    assign dx = $signed({ax[CoordW-1], ax}) - $signed({bx[CoordW-1], bx});
    assign dy = $signed({ay[CoordW-1], ay}) - $signed({by[CoordW-1], by});

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            adx_reg <= dx[CoordW] ? $unsigned(-dx) : $unsigned(dx);
            ady_reg <= dy[CoordW] ? $unsigned(-dy) : $unsigned(dy);
            ax_reg  <= ax;
            ay_reg  <= ay;
            bx_reg  <= bx;
            by_reg  <= by;
        end
    end

    assign sum = (CoordW+2)'(adx_reg) + (CoordW+2)'(ady_reg);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            first_x            <= OutW'(ax_reg);
            first_y            <= OutW'(ay_reg);
            second_x           <= OutW'(bx_reg);
            second_y           <= OutW'(by_reg);
            manhattan_distance <= DistW'(sum);
        end
    end

endmodule

`default_nettype wire

/* rtl/square_spiral_index_distance_unit.sv */
// ----------------------------------------------------------------------------
// square_spiral_index_distance_unit
// maps two spiral indices to grid points and their manhattan distance
// ----------------------------------------------------------------------------
//  channel   handshake                    payload
//  index     index_valid / index_stall    first_index, second_index
//  result    result_valid / result_stall  first_x, first_y, second_x,
//                                         second_y, manhattan_distance
//
//  one item per cycle while the result side is not stalled; the square root
//  pipeline produces one root bit per stage in each lane
//  reset clears the stage valid bits only, payload registers are not reset
//  a stalled result freezes the whole pipeline and stalls the index side
// ----------------------------------------------------------------------------
`default_nettype none

module square_spiral_index_distance_unit #(
    parameter int INDEX_WIDTH = ssid_pkg::INDEX_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                index_valid,
    output logic                                     index_stall,
    input  wire logic [INDEX_WIDTH-1:0]              first_index,
    input  wire logic [INDEX_WIDTH-1:0]              second_index,
    output logic                                     result_valid,
    input  wire logic                                result_stall,
    output logic signed [ssid_pkg::COORD_W-1:0]      first_x,
    output logic signed [ssid_pkg::COORD_W-1:0]      first_y,
    output logic signed [ssid_pkg::COORD_W-1:0]      second_x,
    output logic signed [ssid_pkg::COORD_W-1:0]      second_y,
    output logic [ssid_pkg::DIST_W-1:0]              manhattan_distance
);

    localparam int RootW  = (INDEX_WIDTH + 1) / 2;
    localparam int CoordW = RootW + 4;
    localparam int Depth  = RootW + 5;

    logic             advance;
    logic [Depth-1:0] valid_reg;
    logic [Depth-1:0] valid_next;

    assign advance     = !(valid_reg[Depth-1] && result_stall);
    assign index_stall = !advance;
    assign valid_next  = {valid_reg[Depth-2:0], index_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    assign result_valid = valid_reg[Depth-1];

    logic signed [CoordW-1:0] ax, ay, bx, by;

    ssid_lane #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_lane_first (
        .clk     (clk),
        .advance (advance),
        .index   (first_index),
        .x       (ax),
        .y       (ay)
    );

    ssid_lane #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_lane_second (
        .clk     (clk),
        .advance (advance),
        .index   (second_index),
        .x       (bx),
        .y       (by)
    );

    ssid_merge #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_merge (
        .clk                (clk),
        .advance            (advance),
        .ax                 (ax),
        .ay                 (ay),
        .bx                 (bx),
        .by                 (by),
        .first_x            (first_x),
        .first_y            (first_y),
        .second_x           (second_x),
        .second_y           (second_y),
        .manhattan_distance (manhattan_distance)
    );

endmodule

`default_nettype wire

/* rtl/ssid_checker.sv */
// ----------------------------------------------------------------------------
// ssid_checker
// port-level checks for the square spiral index distance unit
// ----------------------------------------------------------------------------
`default_nettype none

module ssid_checker #(
    parameter int INDEX_WIDTH = ssid_pkg::INDEX_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                index_valid,
    input  wire logic                                index_stall,
    input  wire logic [INDEX_WIDTH-1:0]              first_index,
    input  wire logic [INDEX_WIDTH-1:0]              second_index,
    input  wire logic                                result_valid,
    input  wire logic                                result_stall,
    input  wire logic signed [ssid_pkg::COORD_W-1:0] first_x,
    input  wire logic signed [ssid_pkg::COORD_W-1:0] first_y,
    input  wire logic signed [ssid_pkg::COORD_W-1:0] second_x,
    input  wire logic signed [ssid_pkg::COORD_W-1:0] second_y,
    input  wire logic [ssid_pkg::DIST_W-1:0]         manhattan_distance
);

    // a waiting index item keeps its payload
    a_index_hold: assert property (@(posedge clk) disable iff (!rst_n)
        index_valid && index_stall |=> index_valid && $stable(first_index)
            && $stable(second_index))
        else $error("stalled index item changed");

    // a held result keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(first_x)
            && $stable(first_y) && $stable(second_x) && $stable(second_y)
            && $stable(manhattan_distance))
        else $error("stalled result item changed");

    // the index side only waits on a blocked result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        index_stall |-> result_valid && result_stall)
        else $error("index stalled without a blocked result");

    // same point means zero distance
    a_same_point: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && first_x == second_x && first_y == second_y
            |-> manhattan_distance == '0)
        else $error("nonzero distance between equal points");

    // distance parity follows the coordinate parities
    a_parity: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> manhattan_distance[0]
            == (first_x[0] ^ first_y[0] ^ second_x[0] ^ second_y[0]))
        else $error("distance parity mismatch");

endmodule

bind square_spiral_index_distance_unit ssid_checker #(
    .INDEX_WIDTH (INDEX_WIDTH)
) u_ssid_checker (.*);

`default_nettype wire

/* test/spiral_pair_checker.sv */
// ----------------------------------------------------------------------------
// spiral_pair_checker
// watches both channels of the spiral index distance unit, predicts the two
// grid points and their distance for every accepted index pair, and compares
// every accepted result in order against the oldest prediction
// ----------------------------------------------------------------------------
`default_nettype none

module spiral_pair_checker #(
    parameter int IW = ssid_pkg::INDEX_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                index_valid,
    input  wire logic                                index_stall,
    input  wire logic [IW-1:0]                       first_index,
    input  wire logic [IW-1:0]                       second_index,
    input  wire logic                                result_valid,
    input  wire logic                                result_stall,
    input  wire logic signed [ssid_pkg::COORD_W-1:0] first_x,
    input  wire logic signed [ssid_pkg::COORD_W-1:0] first_y,
    input  wire logic signed [ssid_pkg::COORD_W-1:0] second_x,
    input  wire logic signed [ssid_pkg::COORD_W-1:0] second_y,
    input  wire logic [ssid_pkg::DIST_W-1:0]         manhattan_distance,
    output int                                       mismatch_count,
    output int                                       pairs_waiting,
    output int                                       pairs_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [ssid_pkg::COORD_W-1:0] fx;
        logic signed [ssid_pkg::COORD_W-1:0] fy;
        logic signed [ssid_pkg::COORD_W-1:0] sx;
        logic signed [ssid_pkg::COORD_W-1:0] sy;
        logic [ssid_pkg::DIST_W-1:0]         mdist;
    } spiral_pair_t;

    spiral_pair_t expected_pairs[$];
    spiral_pair_t want;
    int           errors  = 0;
    int           checked = 0;

    assign mismatch_count = errors;
    assign pairs_checked  = checked;

    initial pairs_waiting = 0;

    // floor of the square root by bisection, bounded so mid*mid stays in 64 bits
    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = 64'd3037000499;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            if (mid * mid <= v)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    // ring k spans (2k-1)^2+1 .. (2k+1)^2, walked from corner (-k,-k)
    task automatic locate(input longint unsigned idx, output longint x, output longint y);
        longint k;
        longint h;
        if (idx <= 1)
        begin
            x = 0;
            y = 0;
        end
        else
        begin
            k = longint'((floor_root(idx - 1) + 1) >> 1);
            h = longint'(idx) - (2 * k - 1) * (2 * k - 1);
            if (h <= 2 * k)
            begin
                x = -k + h;
                y = -k;
            end
            else if (h <= 4 * k)
            begin
                x = k;
                y = -k + (h - 2 * k);
            end
            else if (h <= 6 * k)
            begin
                x = k - (h - 4 * k);
                y = k;
            end
            else
            begin
                x = -k;
                y = k - (h - 6 * k);
            end
        end
    endtask

    function automatic longint distance_1d(input longint a, input longint b);
        return (a >= b) ? a - b : b - a;
    endfunction

    task automatic predict_pair(input logic [IW-1:0] a, input logic [IW-1:0] b);
        longint       x1;
        longint       y1;
        longint       x2;
        longint       y2;
        longint       d;
        spiral_pair_t p;
        locate(longint'(a), x1, y1);
        locate(longint'(b), x2, y2);
        d       = distance_1d(x1, x2) + distance_1d(y1, y2);
        p.fx    = x1[ssid_pkg::COORD_W-1:0];
        p.fy    = y1[ssid_pkg::COORD_W-1:0];
        p.sx    = x2[ssid_pkg::COORD_W-1:0];
        p.sy    = y2[ssid_pkg::COORD_W-1:0];
        p.mdist = d[ssid_pkg::DIST_W-1:0];
        expected_pairs.insert(expected_pairs.size(), p);
    endtask

    task automatic check_field(input string field, input longint exp_v, input longint got_v);
        if (exp_v != got_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, exp_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_pairs.size() == 0)
                begin
                    $display("%0t ns: result item with nothing expected, (%0d,%0d) (%0d,%0d) dist %0d",
                             $time, first_x, first_y, second_x, second_y, manhattan_distance);
                    errors++;
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    check_field("first_x", want.fx, first_x);
                    check_field("first_y", want.fy, first_y);
                    check_field("second_x", want.sx, second_x);
                    check_field("second_y", want.sy, second_y);
                    check_field("manhattan_distance", want.mdist, manhattan_distance);
                    checked++;
                end
            end
            if (index_valid && !index_stall)
                predict_pair(first_index, second_index);
        end
        pairs_waiting <= expected_pairs.size();
    end

endmodule

`default_nettype wire

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// drives index pairs into the spiral index distance unit with random gaps
// and result stalls; a directed set hits ring corners, edges and the extremes
// of the index range, then random pairs lean toward ring boundaries
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IW          = ssid_pkg::INDEX_WIDTH_DEF;
    localparam int PIPE_DEPTH  = (IW + 1) / 2 + 5;
    localparam int RANDOM_PAIRS = 850;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_WAIT    = 18;
    localparam int N_DIRECTED  = 21;

    logic                                clk          = 1'b0;
    logic                                rst_n        = 1'b0;
    logic                                index_valid  = 1'b0;
    logic [IW-1:0]                       first_index  = '0;
    logic [IW-1:0]                       second_index = '0;
    logic                                result_stall = 1'b0;
    logic                                index_stall;
    logic                                result_valid;
    logic signed [ssid_pkg::COORD_W-1:0] first_x;
    logic signed [ssid_pkg::COORD_W-1:0] first_y;
    logic signed [ssid_pkg::COORD_W-1:0] second_x;
    logic signed [ssid_pkg::COORD_W-1:0] second_y;
    logic [ssid_pkg::DIST_W-1:0]         manhattan_distance;

    int mismatch_count;
    int pairs_waiting;
    int pairs_checked;
    int pairs_sent  = 0;
    int cycle_count = 0;
    bit quiet_phase = 1'b0;

    // ring ends and starts, segment turns, zero and the top of the range
    logic [31:0] directed_first [N_DIRECTED] = '{
        32'd1, 32'd0, 32'd1, 32'd2, 32'd3, 32'd7, 32'd91, 32'd92, 32'd101, 32'd112,
        32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd4294836225, 32'd4294836226,
        32'h8000_0000, 32'h5555_5555, 32'd0, 32'd4294901761, 32'd10, 32'd0
    };
    logic [31:0] directed_second [N_DIRECTED] = '{
        32'd1, 32'd1, 32'd0, 32'd9, 32'd5, 32'd8, 32'd121, 32'd111, 32'd102, 32'd82,
        32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd4294836226, 32'hFFFF_FFFF,
        32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'd4294901762, 32'd25, 32'd0
    };

    square_spiral_index_distance_unit #(
        .INDEX_WIDTH (IW)
    ) i_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .index_valid        (index_valid),
        .index_stall        (index_stall),
        .first_index        (first_index),
        .second_index       (second_index),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .first_x            (first_x),
        .first_y            (first_y),
        .second_x           (second_x),
        .second_y           (second_y),
        .manhattan_distance (manhattan_distance)
    );

    spiral_pair_checker #(
        .IW (IW)
    ) i_checker (
        .clk                (clk),
        .rst_n              (rst_n),
        .index_valid        (index_valid),
        .index_stall        (index_stall),
        .first_index        (first_index),
        .second_index       (second_index),
        .result_valid       (result_valid),
        .result_stall       (result_stall),
        .first_x            (first_x),
        .first_y            (first_y),
        .second_x           (second_x),
        .second_y           (second_y),
        .manhattan_distance (manhattan_distance),
        .mismatch_count     (mismatch_count),
        .pairs_waiting      (pairs_waiting),
        .pairs_checked      (pairs_checked)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

    function automatic int idle_cycles();
        if (quiet_phase)
            return 0;
        return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // many indices right at or near ring boundaries and segment turns
    function automatic logic [IW-1:0] pick_index();
        int      sel;
        longint  k;
        longint  base;
        longint  idx;
        sel = $urandom_range(0, 99);
        if (sel < 35)
            idx = longint'($urandom());
        else if (sel < 55)
            idx = $urandom_range(1, 300);
        else if (sel < 85)
        begin
            k    = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 32767);
            base = (2 * k - 1) * (2 * k - 1);
            case ($urandom_range(0, 8))
                0: idx = base;
                1: idx = base + 1;
                2: idx = base + 2 * k;
                3: idx = base + 2 * k + 1;
                4: idx = base + 4 * k;
                5: idx = base + 4 * k + 1;
                6: idx = base + 6 * k;
                7: idx = base + 6 * k + 1;
                default: idx = base + 8 * k;
            endcase
        end
        else if (sel < 98)
        begin
            k   = $urandom_range(1, 65535);
            idx = k * k + $urandom_range(0, 4) - 2;
            if (idx < 1)
                idx = 1;
            if (idx > 64'hFFFF_FFFF)
                idx = 64'hFFFF_FFFF;
        end
        else
            idx = 0;
        return idx[IW-1:0];
    endfunction

    task automatic send_pair(input logic [IW-1:0] a, input logic [IW-1:0] b);
        int gap;
        // every third block of 64 items runs with no idling on either side
        quiet_phase = ((pairs_sent / 64) % 3 == 2);
        gap = idle_cycles();
        if (gap > 0)
        begin
            index_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        index_valid  <= 1'b1;
        first_index  <= a;
        second_index <= b;
        do
            @(posedge clk);
        while (index_stall);
        pairs_sent++;
    endtask

    initial
    begin : result_side
        int hold;
        forever
        begin
            hold = idle_cycles();
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            do
                @(posedge clk);
            while (!result_valid);
        end
    end

    initial
    begin : index_side
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < N_DIRECTED; i++)
            send_pair(directed_first[i], directed_second[i]);
        for (int i = 0; i < RANDOM_PAIRS; i++)
            send_pair(pick_index(), pick_index());
        index_valid <= 1'b0;
        @(posedge clk);
        while (pairs_waiting != 0)
            @(posedge clk);
        repeat (2 * PIPE_DEPTH) @(posedge clk);
        $display("sent %0d index pairs (%0d directed), checked %0d results", pairs_sent,
                 N_DIRECTED, pairs_checked);
        $display("random gaps and result stalls of 0 to %0d cycles, %0d mismatches",
                 MAX_WAIT, mismatch_count);
        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire
